// File: sv/uct_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the USB control transfer sequencer.
package uct_pkg;

  localparam int unsigned CFG_DATA_W = 10;

  typedef enum logic [0:0] {
    REG_FIRST_DATA_REQUEST = 1'b0,
    REG_NEXT_DATA_REQUEST  = 1'b1
  } reg_index_t;

  localparam logic [9:0] FIRST_DATA_REQUEST_RESET = 10'd64;
  localparam logic [9:0] NEXT_DATA_REQUEST_RESET  = 10'd8;
  localparam logic [9:0] SETUP_BYTES              = 10'd8;

  typedef enum logic [1:0] {
    MODE_START    = 2'd0,
    MODE_COMPLETE = 2'd1,
    MODE_ERROR    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_SETUP   = 3'd1,
    CMD_DATA_IN = 3'd2,
    CMD_ZLP_OUT = 3'd3,
    CMD_ZLP_IN  = 3'd4
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'b00001,
    PH_SETUP      = 5'b00010,
    PH_STATUS_IN  = 5'b00100,
    PH_DATA       = 5'b01000,
    PH_STATUS_OUT = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  device_address;
    logic [15:0] setup_length;
    logic [9:0]  rx_length;
  } event_t;

  typedef struct packed {
    cmd_t        command;
    logic [6:0]  target_address;
    logic        packet_pid;
    logic [9:0]  request_length;
    logic [15:0] data_offset;
    logic        done_res;
    logic        success;
    logic [15:0] actual_length;
  } result_t;

  typedef struct packed {
    logic [9:0] first_data_request;
    logic [9:0] next_data_request;
  } cfg_t;

endpackage

// File: sv/uct_chan_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one item of payload type T.
interface uct_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

// File: sv/uct_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration registers for the data IN request lengths.
module uct_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  uct_pkg::reg_index_t             cfg_index,
  input  logic [uct_pkg::CFG_DATA_W-1:0]  cfg_data,
  output uct_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_data_request <= uct_pkg::FIRST_DATA_REQUEST_RESET;
      cfg.next_data_request  <= uct_pkg::NEXT_DATA_REQUEST_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        uct_pkg::REG_FIRST_DATA_REQUEST: cfg.first_data_request <= cfg_data;
        uct_pkg::REG_NEXT_DATA_REQUEST:  cfg.next_data_request  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/uct_core.sv
`timescale 1ns / 1ps
// Transfer state registers and the phase logic that turns one event into one result.
module uct_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  uct_pkg::event_t  evt,
  input  uct_pkg::cfg_t    cfg,
  output uct_pkg::result_t result
);

  uct_pkg::phase_t phase, phase_next;
  logic [15:0]     expected_length, expected_length_next;
  logic [15:0]     byte_offset, byte_offset_next;
  logic            data_toggle, data_toggle_next;
  logic [6:0]      current_address, current_address_next;

  logic [16:0]     sum;
  logic [15:0]     sum_sat;

  assign sum     = {1'b0, byte_offset} + {7'b0, evt.rx_length};
  assign sum_sat = sum[16] ? 16'hFFFF : sum[15:0];

  always_comb begin
    phase_next           = phase;
    expected_length_next = expected_length;
    byte_offset_next     = byte_offset;
    data_toggle_next     = data_toggle;
    current_address_next = current_address;
    result               = '0;
    result.command       = uct_pkg::CMD_NONE;

    case (evt.mode)
      uct_pkg::MODE_START: begin
        current_address_next  = evt.device_address;
        expected_length_next  = evt.setup_length;
        byte_offset_next      = '0;
        phase_next            = uct_pkg::PH_SETUP;
        result.command        = uct_pkg::CMD_SETUP;
        result.target_address = evt.device_address;
        result.request_length = uct_pkg::SETUP_BYTES;
      end
      uct_pkg::MODE_COMPLETE: begin
        case (phase)
          uct_pkg::PH_SETUP: begin
            data_toggle_next      = 1'b1;
            result.target_address = current_address;
            result.packet_pid     = 1'b1;
            if (expected_length == '0) begin
              phase_next     = uct_pkg::PH_STATUS_IN;
              result.command = uct_pkg::CMD_ZLP_IN;
            end else begin
              phase_next            = uct_pkg::PH_DATA;
              result.command        = uct_pkg::CMD_DATA_IN;
              result.request_length = cfg.first_data_request;
            end
          end
          uct_pkg::PH_STATUS_IN: begin
            phase_next      = uct_pkg::PH_IDLE;
            result.done_res = 1'b1;
            result.success  = 1'b1;
          end
          uct_pkg::PH_DATA: begin
            result.data_offset    = byte_offset;
            result.target_address = current_address;
            byte_offset_next      = sum_sat;
            // A short run ends on a zero-length packet or once wLength is covered.
            if (evt.rx_length != '0 && sum_sat < expected_length) begin
              data_toggle_next      = ~data_toggle;
              result.command        = uct_pkg::CMD_DATA_IN;
              result.packet_pid     = ~data_toggle;
              result.request_length = cfg.next_data_request;
            end else begin
              phase_next        = uct_pkg::PH_STATUS_OUT;
              result.command    = uct_pkg::CMD_ZLP_OUT;
              result.packet_pid = 1'b1;
            end
          end
          uct_pkg::PH_STATUS_OUT: begin
            phase_next           = uct_pkg::PH_IDLE;
            result.done_res      = 1'b1;
            result.success       = 1'b1;
            result.actual_length = byte_offset;
          end
          default: begin
            phase_next = uct_pkg::PH_IDLE;
          end
        endcase
      end
      uct_pkg::MODE_ERROR: begin
        if (phase != uct_pkg::PH_IDLE) begin
          phase_next      = uct_pkg::PH_IDLE;
          result.done_res = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= uct_pkg::PH_IDLE;
      expected_length <= '0;
      byte_offset     <= '0;
      data_toggle     <= 1'b1;
      current_address <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      expected_length <= expected_length_next;
      byte_offset     <= byte_offset_next;
      data_toggle     <= data_toggle_next;
      current_address <= current_address_next;
    end
  end

endmodule

// File: sv/uct_out_stage.sv
`timescale 1ns / 1ps
// Result register between the phase logic and the result channel.
module uct_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  uct_pkg::result_t result,
  output logic             space,
  uct_chan_if.source       res
);

  logic             full;
  uct_pkg::result_t held;

  // The register can take a new item when empty or when its item leaves now.
  assign space     = !full || res.ready;
  assign res.valid = full;
  assign res.data  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (space) begin
      full <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      held <= result;
    end
  end

endmodule

// File: sv/usb_control_transfer_sequencer.sv
`timescale 1ns / 1ps
// Top level of the host-side USB control-IN transfer sequencer.
// Each event item (start, transaction complete, bus error) produces exactly one
// result item, registered in the cycle after the event is taken. The block takes
// one event per cycle; the only thing that holds it back is the result register,
// which accepts a new item when it is empty or being emptied in the same cycle.
// Request lengths for the data stage are set through the write port and should
// only be changed while no transfer item is in flight.
module usb_control_transfer_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  uct_pkg::reg_index_t             cfg_index,
  input  logic [uct_pkg::CFG_DATA_W-1:0]  cfg_data,
  uct_chan_if.sink                        evt,
  uct_chan_if.source                      res
);

  uct_pkg::cfg_t    cfg;
  uct_pkg::result_t result;
  logic             space;
  logic             accept;

  assign evt.ready = space;
  assign accept    = evt.valid && space;

  uct_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  uct_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .evt    (evt.data),
    .cfg    (cfg),
    .result (result)
  );

  uct_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (evt.valid),
    .result (result),
    .space  (space),
    .res    (res)
  );

endmodule

// File: sv/uct_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the sequencer and the bind that attaches them.
module uct_checker (
  input logic             clk,
  input logic             rst,
  input logic             evt_valid,
  input logic             evt_ready,
  input logic             res_valid,
  input logic             res_ready,
  input uct_pkg::result_t res_data
);

  // Every taken event shows up as a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_ready |=> res_valid)
    else $error("event taken without a result on the next cycle");

  a_idle_command: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.command == uct_pkg::CMD_NONE |->
      res_data.target_address == '0 && !res_data.packet_pid &&
      res_data.request_length == '0)
    else $error("empty command carries address, toggle or length");

  a_success_needs_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.done_res |->
      !res_data.success && res_data.actual_length == '0)
    else $error("completion status without done");

  a_failure_no_length: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.done_res && !res_data.success |->
      res_data.actual_length == '0 && res_data.command == uct_pkg::CMD_NONE)
    else $error("failed transfer reports a length or a command");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

endmodule

bind usb_control_transfer_sequencer uct_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .evt_valid (evt.valid),
  .evt_ready (evt.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);
